// ===== rtl/dda_lpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDA line point generator package
// Command codes shared by the front end and the back end of the generator.
// ----------------------------------------------------------------------------
package dda_lpg_pkg;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/dda_lpg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDA line point generator front end
// Accepts command words, forms the endpoint deltas, their magnitudes and the
// line length, and passes the classified word on to the queue.
// ----------------------------------------------------------------------------
module dda_lpg_front
    import dda_lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         command,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output logic [5*COORD_BITS+2:0]           push_data
);

    localparam int C = COORD_BITS;

    typedef struct packed {
        cmd_t         cmd;
        logic [C-1:0] sx;
        logic [C-1:0] sy;
        logic [C-1:0] ax;
        logic [C-1:0] ay;
        logic         neg_x;
        logic         neg_y;
        logic [C-1:0] len;
    } entry_t;

    entry_t     e;
    logic [C:0] dx;
    logic [C:0] dy;
    logic [C:0] mag_x;
    logic [C:0] mag_y;

    assign dx    = {end_x[C-1], end_x} - {start_x[C-1], start_x};
    assign dy    = {end_y[C-1], end_y} - {start_y[C-1], start_y};
    assign mag_x = dx[C] ? (~dx + {{C{1'b0}}, 1'b1}) : dx;
    assign mag_y = dy[C] ? (~dy + {{C{1'b0}}, 1'b1}) : dy;

    always_comb
    begin
        e.cmd   = cmd_t'(command);
        e.sx    = start_x;
        e.sy    = start_y;
        e.ax    = mag_x[C-1:0];
        e.ay    = mag_y[C-1:0];
        e.neg_x = dx[C];
        e.neg_y = dy[C];
        e.len   = (mag_y > mag_x) ? mag_y[C-1:0] : mag_x[C-1:0];
    end

    assign push_data  = e;
    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule
`default_nettype wire

// ===== rtl/dda_lpg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDA line point generator queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dda_lpg_queue #(
    parameter int WIDTH = 63
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dda_lpg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDA line point generator back end
// Executes queued words: nonzero-length loads start a restoring division for
// both increments, steps on an active line advance the fixed-point accumulators
// and round the point; other steps give an empty word.
module dda_lpg_back
    import dda_lpg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire logic [5*COORD_BITS+2:0] q_entry,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                       point_valid,
    output logic                       last_point
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int AW = C + F + 2;
    localparam int NW = C + F + 1;
    localparam int CW = $clog2(F + 1);

    typedef struct packed {
        cmd_t         cmd;
        logic [C-1:0] sx;
        logic [C-1:0] sy;
        logic [C-1:0] ax;
        logic [C-1:0] ay;
        logic         neg_x;
        logic         neg_y;
        logic [C-1:0] len;
    } entry_t;

    typedef enum logic [1:0] {
        ST_RUN = 2'b01,
        ST_DIV = 2'b10
    } back_state_t;

    function automatic logic [C:0] div_step(input logic [C-1:0] rem,
                                            input logic         nbit,
                                            input logic [C-1:0] dvs);
        logic [C:0] t;
        logic [C:0] d;
        t = {rem, nbit};
        d = t - {1'b0, dvs};
        if (t >= {1'b0, dvs})
        begin
            return {d[C-1:0], 1'b1};
        end
        return {t[C-1:0], 1'b0};
    endfunction

    function automatic logic [AW-1:0] add_inc(input logic [AW-1:0] acc,
                                              input logic [F:0]    mag,
                                              input logic          neg);
        logic [AW-1:0] m;
        m = {{(AW-F-1){1'b0}}, mag};
        return acc + (neg ? ~m : m) + {{(AW-1){1'b0}}, neg};
    endfunction

    function automatic logic [C-1:0] round_px(input logic [AW-1:0] acc,
                                              input logic [AW-1:0] bias);
        logic corr;
        corr = acc[AW-1] && (bias[F-1:0] == '0);
        return bias[F +: C] - {{(C-1){1'b0}}, corr};
    endfunction

    back_state_t   state_reg;
    logic [CW-1:0] cnt_reg;
    logic [C-1:0]  steps_left_reg;
    logic          active_reg;
    logic          out_valid_reg;
    logic [C-1:0]  rem_x_reg;
    logic [C-1:0]  rem_y_reg;
    logic [F:0]    quo_x_reg;
    logic [F:0]    quo_y_reg;
    logic          neg_x_reg;
    logic          neg_y_reg;
    logic [AW-1:0] acc_x_reg;
    logic [AW-1:0] acc_y_reg;
    logic [AW-1:0] bias_x_reg;
    logic [AW-1:0] bias_y_reg;
    logic [C-1:0]  pixel_x_reg;
    logic [C-1:0]  pixel_y_reg;
    logic          point_valid_reg;
    logic          last_point_reg;

    entry_t        e;
    logic          slot_free;
    logic          pop;
    logic          is_load;
    logic          len_zero;
    logic [NW-1:0] num_x;
    logic [NW-1:0] num_y;
    logic [C:0]    dstep_x;
    logic [C:0]    dstep_y;
    logic [AW-1:0] acc_x_next;
    logic [AW-1:0] acc_y_next;
    logic [AW-1:0] bias_x_next;
    logic [AW-1:0] bias_y_next;
    logic [AW-1:0] start_acc_x;
    logic [AW-1:0] start_acc_y;

    assign e         = q_entry;
    assign slot_free = !out_valid_reg || out_ready;
    assign q_ready   = (state_reg == ST_RUN) && slot_free;
    assign pop       = q_valid && q_ready;
    assign is_load   = (e.cmd == CMD_LOAD);
    assign len_zero  = (e.len == '0);

    assign num_x = {1'b0, e.ax, {F{1'b0}}} + {{(F+1){1'b0}}, 1'b0, e.len[C-1:1]};
    assign num_y = {1'b0, e.ay, {F{1'b0}}} + {{(F+1){1'b0}}, 1'b0, e.len[C-1:1]};

    assign dstep_x = div_step(rem_x_reg, quo_x_reg[F], steps_left_reg);
    assign dstep_y = div_step(rem_y_reg, quo_y_reg[F], steps_left_reg);

    assign acc_x_next  = add_inc(acc_x_reg, quo_x_reg, neg_x_reg);
    assign acc_y_next  = add_inc(acc_y_reg, quo_y_reg, neg_y_reg);
    assign bias_x_next = add_inc(bias_x_reg, quo_x_reg, neg_x_reg);
    assign bias_y_next = add_inc(bias_y_reg, quo_y_reg, neg_y_reg);

    assign start_acc_x = {{2{e.sx[C-1]}}, e.sx, {F{1'b0}}};
    assign start_acc_y = {{2{e.sy[C-1]}}, e.sy, {F{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            cnt_reg        <= '0;
            steps_left_reg <= '0;
            active_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN:
                begin
                    if (pop)
                    begin
                        if (is_load)
                        begin
                            steps_left_reg <= e.len;
                            active_reg     <= !len_zero;
                            if (!len_zero)
                            begin
                                state_reg <= ST_DIV;
                                cnt_reg   <= CW'(F);
                            end
                        end
                        else if (active_reg)
                        begin
                            steps_left_reg <= steps_left_reg - {{(C-1){1'b0}}, 1'b1};
                            if (steps_left_reg == {{(C-1){1'b0}}, 1'b1})
                            begin
                                active_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_RUN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - {{(CW-1){1'b0}}, 1'b1};
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV)
        begin
            rem_x_reg <= dstep_x[C:1];
            rem_y_reg <= dstep_y[C:1];
            quo_x_reg <= {quo_x_reg[F-1:0], dstep_x[0]};
            quo_y_reg <= {quo_y_reg[F-1:0], dstep_y[0]};
        end
        else if (pop)
        begin
            if (is_load)
            begin
                pixel_x_reg     <= e.sx;
                pixel_y_reg     <= e.sy;
                point_valid_reg <= 1'b1;
                last_point_reg  <= len_zero;
                acc_x_reg       <= start_acc_x;
                acc_y_reg       <= start_acc_y;
                bias_x_reg      <= {{2{e.sx[C-1]}}, e.sx, 1'b1, {(F-1){1'b0}}};
                bias_y_reg      <= {{2{e.sy[C-1]}}, e.sy, 1'b1, {(F-1){1'b0}}};
                neg_x_reg       <= e.neg_x;
                neg_y_reg       <= e.neg_y;
                rem_x_reg       <= num_x[NW-1:F+1];
                rem_y_reg       <= num_y[NW-1:F+1];
                quo_x_reg       <= num_x[F:0];
                quo_y_reg       <= num_y[F:0];
            end
            else if (active_reg)
            begin
                acc_x_reg       <= acc_x_next;
                acc_y_reg       <= acc_y_next;
                bias_x_reg      <= bias_x_next;
                bias_y_reg      <= bias_y_next;
                pixel_x_reg     <= round_px(acc_x_next, bias_x_next);
                pixel_y_reg     <= round_px(acc_y_next, bias_y_next);
                point_valid_reg <= 1'b1;
                last_point_reg  <= (steps_left_reg == {{(C-1){1'b0}}, 1'b1});
            end
            else
            begin
                pixel_x_reg     <= '0;
                pixel_y_reg     <= '0;
                point_valid_reg <= 1'b0;
                last_point_reg  <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign point_valid = point_valid_reg;
    assign last_point  = last_point_reg;

endmodule
`default_nettype wire

// ===== rtl/dda_line_point_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DDA line point generator
// Fixed-point DDA rasteriser: a load word returns the start point, each step
// word on an active line returns the next rounded point, others an empty word.
// ----------------------------------------------------------------------------
// A stream of step words yields one point per clock while each point is
// accepted at once and no division runs. A load of a line with nonzero length
// returns its start point and then runs the restoring division that forms both
// increments side by side, one quotient bit per cycle; a zero-length load only
// returns its start point. The front end keeps accepting words into a two-entry
// queue while the division runs, and outside it the back end takes the next word
// in the same cycle as the point in its output register is accepted.
// ----------------------------------------------------------------------------
module dda_line_point_generator_unit
    import dda_lpg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         command,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic                              point_valid,
    output logic                              last_point
);

    localparam int ENTRY_W = 5 * COORD_BITS + 3;

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               q_valid;
    logic               q_ready;
    logic [ENTRY_W-1:0] q_entry;

    dda_lpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dda_lpg_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_entry)
    );

    dda_lpg_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_entry     (q_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .point_valid (point_valid),
        .last_point  (last_point)
    );

    a_pop_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> out_valid
    ) else $error("word taken from the queue produced no output word");

    a_last_is_point: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && last_point |-> point_valid
    ) else $error("last point flagged on an empty word");

    a_empty_is_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> (pixel_x == '0) && (pixel_y == '0)
    ) else $error("empty word carries nonzero coordinates");

endmodule
`default_nettype wire
